/* design/xmpe_pkg.sv */
// Shared types and constants for the 8086 MOV/PUSH/POP/XCHG encoder.
package xmpe_pkg;

    localparam int MAX_BYTES     = 6;
    localparam int BYTE_IDX_W    = 3;
    localparam int QDEPTH_DEFAULT = 4;

    typedef enum logic [3:0] {
        ACT_MOV_RM      = 4'd0,
        ACT_MOV_IMM_RM  = 4'd1,
        ACT_MOV_IMM_REG = 4'd2,
        ACT_MOV_MEM_ACC = 4'd3,
        ACT_MOV_ACC_MEM = 4'd4,
        ACT_MOV_RM_SREG = 4'd5,
        ACT_MOV_SREG_RM = 4'd6,
        ACT_PUSH_RM     = 4'd7,
        ACT_PUSH_REG    = 4'd8,
        ACT_PUSH_SREG   = 4'd9,
        ACT_POP_RM      = 4'd10,
        ACT_POP_REG     = 4'd11,
        ACT_POP_SREG    = 4'd12,
        ACT_XCHG_RM     = 4'd13,
        ACT_XCHG_ACC    = 4'd14
    } act_t;

    localparam logic [7:0] OP_MOV_RM      = 8'h88;
    localparam logic [7:0] OP_MOV_IMM_RM  = 8'hC6;
    localparam logic [7:0] OP_MOV_IMM_REG = 8'hB0;
    localparam logic [7:0] OP_MOV_MEM_ACC = 8'hA0;
    localparam logic [7:0] OP_MOV_ACC_MEM = 8'hA2;
    localparam logic [7:0] OP_MOV_RM_SREG = 8'h8E;
    localparam logic [7:0] OP_MOV_SREG_RM = 8'h8C;
    localparam logic [7:0] OP_PUSH_RM     = 8'hFF;
    localparam logic [7:0] OP_PUSH_REG    = 8'h50;
    localparam logic [7:0] OP_PUSH_SREG   = 8'h06;
    localparam logic [7:0] OP_POP_RM      = 8'h8F;
    localparam logic [7:0] OP_POP_REG     = 8'h58;
    localparam logic [7:0] OP_POP_SREG    = 8'h07;
    localparam logic [7:0] OP_XCHG_RM     = 8'h86;
    localparam logic [7:0] OP_XCHG_ACC    = 8'h90;

    localparam logic [2:0] MID_PUSH_RM  = 3'd6;
    localparam logic [2:0] MID_ZERO     = 3'd0;
    localparam logic [2:0] RM_DIRECT    = 3'd6;

    typedef struct packed {
        logic [3:0] action;
        logic       direction;
        logic       wide;
        logic [1:0] mode;
        logic [2:0] reg_field;
        logic [1:0] seg_reg;
        logic [2:0] rm_field;
        logic [7:0] operand_byte0;
        logic [7:0] operand_byte1;
        logic [7:0] operand_byte2;
        logic [7:0] operand_byte3;
    } req_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
    } res_t;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [BYTE_IDX_W-1:0]     count;
    } plan_t;

    typedef struct packed {
        logic  valid;
        plan_t plan;
    } plan_wr_t;

endpackage

/* design/xmpe_front.sv */
// Front end: classifies a request and assembles its byte plan.
module xmpe_front import xmpe_pkg::*; (
    input  req_t     request,
    input  logic     accept,
    output plan_wr_t wr
);

    logic [7:0]       opcode;
    logic [7:0]       modrm;
    logic [2:0]       mid;
    logic             has_modrm;
    logic [2:0]       n_ops;
    logic [2:0]       disp_n;
    logic             known;
    logic [3:0][7:0]  ops;

    assign ops = {request.operand_byte3, request.operand_byte2,
                  request.operand_byte1, request.operand_byte0};

    always_comb
    begin
        unique case (request.mode)
            2'd0:    disp_n = (request.rm_field == RM_DIRECT) ? 3'd2 : 3'd0;
            2'd1:    disp_n = 3'd1;
            2'd2:    disp_n = 3'd2;
            default: disp_n = 3'd0;
        endcase
    end

    always_comb
    begin
        opcode    = 8'h00;
        mid       = request.reg_field;
        has_modrm = 1'b0;
        n_ops     = 3'd0;
        known     = 1'b1;
        unique case (request.action)
            ACT_MOV_RM:
            begin
                opcode    = OP_MOV_RM | {6'b0, request.direction, request.wide};
                has_modrm = 1'b1;
                n_ops     = disp_n;
            end
            ACT_MOV_IMM_RM:
            begin
                opcode    = OP_MOV_IMM_RM | {7'b0, request.wide};
                mid       = MID_ZERO;
                has_modrm = 1'b1;
                n_ops     = disp_n + 3'd1 + {2'b0, request.wide};
            end
            ACT_MOV_IMM_REG:
            begin
                opcode = OP_MOV_IMM_REG | {4'b0, request.wide, request.reg_field};
                n_ops  = 3'd1 + {2'b0, request.wide};
            end
            ACT_MOV_MEM_ACC:
            begin
                opcode = OP_MOV_MEM_ACC | {7'b0, request.wide};
                n_ops  = 3'd2;
            end
            ACT_MOV_ACC_MEM:
            begin
                opcode = OP_MOV_ACC_MEM | {7'b0, request.wide};
                n_ops  = 3'd2;
            end
            ACT_MOV_RM_SREG:
            begin
                opcode    = OP_MOV_RM_SREG;
                mid       = {1'b0, request.seg_reg};
                has_modrm = 1'b1;
                n_ops     = disp_n;
            end
            ACT_MOV_SREG_RM:
            begin
                opcode    = OP_MOV_SREG_RM;
                mid       = {1'b0, request.seg_reg};
                has_modrm = 1'b1;
                n_ops     = disp_n;
            end
            ACT_PUSH_RM:
            begin
                opcode    = OP_PUSH_RM;
                mid       = MID_PUSH_RM;
                has_modrm = 1'b1;
                n_ops     = disp_n;
            end
            ACT_PUSH_REG:  opcode = OP_PUSH_REG | {5'b0, request.reg_field};
            ACT_PUSH_SREG: opcode = OP_PUSH_SREG | {3'b0, request.seg_reg, 3'b0};
            ACT_POP_RM:
            begin
                opcode    = OP_POP_RM;
                mid       = MID_ZERO;
                has_modrm = 1'b1;
                n_ops     = disp_n;
            end
            ACT_POP_REG:   opcode = OP_POP_REG | {5'b0, request.reg_field};
            ACT_POP_SREG:  opcode = OP_POP_SREG | {3'b0, request.seg_reg, 3'b0};
            ACT_XCHG_RM:
            begin
                opcode    = OP_XCHG_RM | {7'b0, request.wide};
                has_modrm = 1'b1;
                n_ops     = disp_n;
            end
            ACT_XCHG_ACC:  opcode = OP_XCHG_ACC | {5'b0, request.reg_field};
            default:       known  = 1'b0;
        endcase
    end

    assign modrm = {request.mode, mid, request.rm_field};

    always_comb
    begin
        if (has_modrm)
        begin
            wr.plan.bytes = {ops[3], ops[2], ops[1], ops[0], modrm, opcode};
            wr.plan.count = n_ops + 3'd2;
        end
        else
        begin
            wr.plan.bytes = {8'h00, ops[3], ops[2], ops[1], ops[0], opcode};
            wr.plan.count = n_ops + 3'd1;
        end
        wr.valid = accept && known;
    end

endmodule

/* design/xmpe_queue.sv */
// Plan queue between the front end and the byte serializer.
module xmpe_queue import xmpe_pkg::*; #(
    parameter int DEPTH = QDEPTH_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    input  plan_wr_t wr,
    input  logic     deq,
    output logic     full,
    output logic     head_valid,
    output plan_t    head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    plan_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_wr      = wr.valid && !full;
    assign do_rd      = deq && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr.plan;
    end

endmodule

/* design/xmpe_back.sv */
// Back end: walks the head plan and drives one code byte per cycle, unless a held, unpopped result stalls it.
module xmpe_back import xmpe_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  head_valid,
    input  plan_t head,
    output logic  deq,
    input  logic  pop,
    output logic  empty,
    output res_t  result
);

    logic [BYTE_IDX_W-1:0] idx_reg, idx_next;
    logic                  out_valid_reg, out_valid_next;
    res_t                  out_reg, out_next;
    logic                  advance;
    logic                  is_last;

    assign advance = !out_valid_reg || pop;
    assign is_last = (idx_reg == head.count - 1'b1);
    assign deq     = advance && head_valid && is_last;
    assign empty   = !out_valid_reg;
    assign result  = out_reg;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
        begin
            out_valid_next = head_valid;
            if (head_valid)
            begin
                out_next.code_byte = head.bytes[idx_reg];
                out_next.last_byte = is_last;
                idx_next           = is_last ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

/* design/x86_16_mov_push_pop_encoder_top.sv */
// Top level of the 8086 MOV/PUSH/POP/XCHG instruction encoder.
// The first code byte of an item passes through the plan queue and then the result register before it is on result.
// Throughput: one code byte per cycle while pop keeps taking the result; an item of n bytes (1 to 6) goes out as
// n code bytes on the result port, so the sustained item rate is set by the byte port.
// The plan queue (QDEPTH entries) lets intake run ahead of the byte port.
// Reset: asynchronous, clears queue pointers and count, the byte index and the result valid flag; queue empty.
module x86_16_mov_push_pop_encoder_top import xmpe_pkg::*; #(
    parameter int QDEPTH = QDEPTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  req_t request,
    output logic empty,
    input  logic pop,
    output res_t result
);

    plan_wr_t wr;
    plan_t    head;
    logic     head_valid;
    logic     deq;

    xmpe_front u_front (
        .request (request),
        .accept  (push && !full),
        .wr      (wr)
    );

    xmpe_queue #(.DEPTH(QDEPTH)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .deq        (deq),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    xmpe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .deq        (deq),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

    a_deq_gives_last: assert property (@(posedge clk) disable iff (!rst_n)
        deq |=> (!empty && result.last_byte))
        else $error("plan retired without a last byte on result");

    a_drain_to_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (!head_valid && !empty && pop) |=> empty)
        else $error("result stayed valid with nothing queued");

    a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(wr.valid))
        else $error("queue filled without a write");

endmodule
